>>> rtl/palu_pkg.sv
// Package for the positional array list unit: payload structs, cell control
// struct, operation and status codes, sizing constants.
// No dependencies.
package palu_pkg;

   localparam int unsigned DEF_CAPACITY   = 32;
   localparam int unsigned DEF_DATA_WIDTH = 32;
   localparam int unsigned MAX_CAPACITY   = 1024;
   localparam int unsigned SLOT_W         = $clog2(MAX_CAPACITY + 1);

   localparam logic [2:0] OP_READ       = 3'd0;
   localparam logic [2:0] OP_INSERT     = 3'd1;
   localparam logic [2:0] OP_APPEND     = 3'd2;
   localparam logic [2:0] OP_ERASE_AT   = 3'd3;
   localparam logic [2:0] OP_ERASE_LAST = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic [2:0]          operation;
      logic [4:0]          position;
      logic signed [31:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  data_out;
      logic [1:0]          status;
      logic [5:0]          length;
   } rsp_type;

   typedef struct packed {
      logic              ins;
      logic              del;
      logic [SLOT_W-1:0] pos;
   } cell_ctrl_type;

endpackage

>>> rtl/palu_cell.sv
// One storage cell of the list row: holds a single entry and takes the
// broadcast word or a neighbour's entry on insert and erase.
// Depends on palu_pkg.
module palu_cell #(
   parameter int unsigned INDEX      = 0,
   parameter int unsigned DATA_WIDTH = palu_pkg::DEF_DATA_WIDTH
) (
   input  logic                    clock,
   input  palu_pkg::cell_ctrl_type ctrl,
   input  logic [DATA_WIDTH-1:0]   wr_data,
   input  logic [DATA_WIDTH-1:0]   left_data,
   input  logic [DATA_WIDTH-1:0]   right_data,
   output logic [DATA_WIDTH-1:0]   data
);

   localparam logic [palu_pkg::SLOT_W-1:0] MY_SLOT = palu_pkg::SLOT_W'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins) begin
         if (MY_SLOT == ctrl.pos) begin
            data_in = wr_data;
         end else if (MY_SLOT > ctrl.pos) begin
            data_in = left_data;
         end
      end else if (ctrl.del) begin
         if (MY_SLOT >= ctrl.pos) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> rtl/positional_array_list_unit.sv
// Top level of the positional array list unit: row of list cells, count,
// operation decode and registered response.
// Depends on palu_pkg and palu_cell.
// A response is registered, valid in the cycle after its request is accepted.
// Throughput: one transaction per cycle while no response is stalled; the
// row shifts as a whole and the read word is one select across the row.
// Reset clears the entry count and the response valid; entries stay undefined.
module positional_array_list_unit #(
   parameter int unsigned CAPACITY   = palu_pkg::DEF_CAPACITY,
   parameter int unsigned DATA_WIDTH = palu_pkg::DEF_DATA_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  palu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output palu_pkg::rsp_type rsp_data
);

   localparam int unsigned CW   = $clog2(CAPACITY + 1);
   localparam int unsigned IDXW = $clog2(CAPACITY);
   localparam int unsigned SW   = palu_pkg::SLOT_W;

   logic [DATA_WIDTH-1:0]   cell_data [CAPACITY];
   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           count_in;
   logic [CW-1:0]           next_count;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   palu_pkg::rsp_type       rsp_ff;
   palu_pkg::rsp_type       rsp_in;
   palu_pkg::cell_ctrl_type ctrl;
   logic                    accept;
   logic                    do_ins;
   logic                    do_del;
   logic [SW-1:0]           count_ext;
   logic [SW-1:0]           pos_ext;
   logic [SW-1:0]           ins_pos;
   logic [SW-1:0]           sel;
   logic [DATA_WIDTH-1:0]   rd_word;
   logic [DATA_WIDTH-1:0]   wr_word;
   logic signed [31:0]      rd_out;
   logic                    full;
   logic                    empty;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign count_ext = SW'(count_ff);
   assign pos_ext   = SW'(req_data.position);
   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign ins_pos   = (req_data.operation == palu_pkg::OP_APPEND) ? count_ext : pos_ext;
   assign sel       = (req_data.operation == palu_pkg::OP_ERASE_LAST) ?
                      (count_ext - SW'(1)) : pos_ext;
   assign rd_word   = cell_data[sel[IDXW-1:0]];
   assign rd_out    = 32'($signed(rd_word));
   assign wr_word   = DATA_WIDTH'(req_data.value);

   always_comb begin
      rsp_in.data_out = '0;
      rsp_in.status   = palu_pkg::ST_OK;
      next_count      = count_ff;
      do_ins          = 1'b0;
      do_del          = 1'b0;
      case (req_data.operation)
         palu_pkg::OP_READ: begin
            if (empty) begin
               rsp_in.status = palu_pkg::ST_EMPTY;
            end else if (pos_ext >= count_ext) begin
               rsp_in.status = palu_pkg::ST_BAD_INDEX;
            end else begin
               rsp_in.data_out = rd_out;
            end
         end
         palu_pkg::OP_INSERT, palu_pkg::OP_APPEND: begin
            if (full) begin
               rsp_in.status = palu_pkg::ST_FULL;
            end else if (ins_pos > count_ext) begin
               rsp_in.status = palu_pkg::ST_BAD_INDEX;
            end else begin
               do_ins     = 1'b1;
               next_count = count_ff + CW'(1);
            end
         end
         palu_pkg::OP_ERASE_AT: begin
            if (empty) begin
               rsp_in.status = palu_pkg::ST_EMPTY;
            end else if (pos_ext >= count_ext) begin
               rsp_in.status = palu_pkg::ST_BAD_INDEX;
            end else begin
               rsp_in.data_out = rd_out;
               do_del          = 1'b1;
               next_count      = count_ff - CW'(1);
            end
         end
         palu_pkg::OP_ERASE_LAST: begin
            if (empty) begin
               rsp_in.status = palu_pkg::ST_EMPTY;
            end else begin
               rsp_in.data_out = rd_out;
               next_count      = count_ff - CW'(1);
            end
         end
         default: begin
            next_count = count_ff;
         end
      endcase
      rsp_in.length = 6'(next_count);
   end

   assign ctrl.ins = accept && do_ins;
   assign ctrl.del = accept && do_del;
   assign ctrl.pos = ins_pos;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [DATA_WIDTH-1:0] left_data;
         logic [DATA_WIDTH-1:0] right_data;
         if (gi == 0) begin : g_first
            assign left_data = '0;
         end else begin : g_mid_l
            assign left_data = cell_data[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign right_data = '0;
         end else begin : g_mid_r
            assign right_data = cell_data[gi+1];
         end
         palu_cell #(
            .INDEX      (gi),
            .DATA_WIDTH (DATA_WIDTH)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .wr_data    (wr_word),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[gi])
         );
      end
   endgenerate

   assign count_in     = accept ? next_count : count_ff;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(accept)) |-> $stable(count_ff))
      else $error("entry count moved without a transaction");

   a_rsp_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.length == 6'(count_ff)))
      else $error("response length differs from entry count");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != palu_pkg::ST_OK)) |-> (rsp_ff.data_out == '0))
      else $error("failed transaction returned data");
`endif

endmodule
